@@ design/lhp_pkg.sv @@
`default_nettype none

package lhp_pkg;

   localparam int BINS       = 256;
   localparam int BIN_BITS   = $clog2(BINS);
   localparam int COUNT_BITS = 32;
   localparam int OUT_BITS   = 32;
   localparam int FRAC_BITS  = 16;
   localparam int RATIO_BITS = FRAC_BITS + 1;
   localparam int CUM_BITS   = COUNT_BITS + BIN_BITS;
   localparam int RHS_BITS   = FRAC_BITS + COUNT_BITS;
   localparam int CMP_BITS   = CUM_BITS + FRAC_BITS;
   localparam int LUMA_BITS  = 16;

   localparam logic [LUMA_BITS-1:0] LUMA_R     = 16'd77;
   localparam logic [LUMA_BITS-1:0] LUMA_G     = 16'd151;
   localparam logic [LUMA_BITS-1:0] LUMA_B     = 16'd28;
   localparam int                   LUMA_SHIFT = 8;

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef logic [BIN_BITS-1:0]   bin_idx_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   localparam bin_idx_type LAST_BIN  = bin_idx_type'(BINS - 1);
   localparam count_type   COUNT_MAX = '1;

   typedef struct packed {
      logic                  command;
      logic [7:0]            red;
      logic [7:0]            green;
      logic [7:0]            blue;
      logic [RATIO_BITS-1:0] ratio;
   } req_type;

   typedef struct packed {
      logic [7:0]          level;
      logic [OUT_BITS-1:0] peak_count;
      logic [OUT_BITS-1:0] pixel_total;
   } rsp_type;

   // write port of the bin store
   typedef struct packed {
      logic        en;
      bin_idx_type addr;
      count_type   data;
   } bin_wr_type;

   function automatic logic [7:0] luma_of(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
      logic [LUMA_BITS-1:0] sum;
      sum = LUMA_BITS'(r) * LUMA_R + LUMA_BITS'(g) * LUMA_G + LUMA_BITS'(b) * LUMA_B;
      return sum[LUMA_SHIFT +: 8];
   endfunction

   function automatic count_type sat_inc(input count_type v);
      return (v == COUNT_MAX) ? COUNT_MAX : v + count_type'(1);
   endfunction

endpackage

`default_nettype wire

@@ design/luma_histogram_percentile.sv @@
`default_nettype none

// Luma histogram with percentile lookup.
// Input: one word on req_word, taken at a clock edge with start high and busy
// low. command ADD folds an RGB pixel into a 256-bin luma histogram; command
// QUERY returns the smallest bin whose cumulative count reaches ratio/65536
// of the pixel total.
// Output: every word gives exactly one result word on rsp_word, valid for one
// cycle while rsp_strobe is high. The receiver cannot stall; results are
// registered, so the next word may be taken in the strobe cycle.
// An add does a read, modify and write of the bin store, which has one registered
// read port. A query with ratio 0, ratio >= 1.0 or an empty histogram answers
// straight from idle. Otherwise a query walks the bins one by one through a single
// add-and-compare unit, each bin a registered read, then accumulate, stopping at
// the first bin that reaches the target or at the last bin.
// Reset (synchronous, active high) clears the control state, the pixel total,
// the peak count and the per-bin valid bits, so all bins read as zero at once.
// Counts saturate at full scale.

module luma_histogram_percentile (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   input  lhp_pkg::req_type req_word,
   output logic             rsp_strobe,
   output lhp_pkg::rsp_type rsp_word
);
   import lhp_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_ADD_RD  = 3'd1;
   localparam logic [2:0] ST_ADD_WR  = 3'd2;
   localparam logic [2:0] ST_QRY_RD  = 3'd3;
   localparam logic [2:0] ST_QRY_ACC = 3'd4;

   logic [2:0]            state_ff, state_in;
   bin_idx_type           idx_ff, idx_in;
   count_type             total_ff, total_in;
   count_type             peak_ff, peak_in;
   logic [CUM_BITS-1:0]   cum_ff, cum_in;
   logic [RHS_BITS-1:0]   rhs_ff, rhs_in;
   logic                  strobe_ff, strobe_in;
   rsp_type               rsp_ff, rsp_in;

   bin_wr_type            wr;
   count_type             rd_data;
   count_type             bin_next;
   logic [CUM_BITS-1:0]   cum_sum;
   logic                  reached;
   logic                  accept;

   lhp_bin_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign accept   = start && (state_ff == ST_IDLE);
   assign bin_next = sat_inc(rd_data);

   // shared unit of the walk: running sum, then cum*65536 >= ratio*total
   assign cum_sum = cum_ff + CUM_BITS'(rd_data);
   assign reached = {cum_sum, FRAC_BITS'(0)} >= CMP_BITS'(rhs_ff);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      total_in  = total_ff;
      peak_in   = peak_ff;
      cum_in    = cum_ff;
      rhs_in    = rhs_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      wr.en     = 1'b0;
      wr.addr   = idx_ff;
      wr.data   = bin_next;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_word.command == CMD_ADD) begin
                  idx_in   = luma_of(req_word.red, req_word.green, req_word.blue);
                  state_in = ST_ADD_RD;
               end else begin
                  idx_in = '0;
                  cum_in = '0;
                  rhs_in = RHS_BITS'(req_word.ratio[FRAC_BITS-1:0]) * RHS_BITS'(total_ff);
                  rsp_in.peak_count  = OUT_BITS'(peak_ff);
                  rsp_in.pixel_total = OUT_BITS'(total_ff);
                  if (req_word.ratio == '0) begin
                     rsp_in.level = 8'(0);
                     strobe_in    = 1'b1;
                  end else if (req_word.ratio[FRAC_BITS] || total_ff == '0) begin
                     rsp_in.level = 8'(LAST_BIN);
                     strobe_in    = 1'b1;
                  end else begin
                     state_in = ST_QRY_RD;
                  end
               end
            end
         end
         ST_ADD_RD: begin
            // bin read in flight
            state_in = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            wr.en    = 1'b1;
            total_in = sat_inc(total_ff);
            if (bin_next > peak_ff) begin
               peak_in = bin_next;
            end
            rsp_in.level       = 8'(idx_ff);
            rsp_in.peak_count  = OUT_BITS'(peak_in);
            rsp_in.pixel_total = OUT_BITS'(total_in);
            strobe_in          = 1'b1;
            state_in           = ST_IDLE;
         end
         ST_QRY_RD: begin
            state_in = ST_QRY_ACC;
         end
         ST_QRY_ACC: begin
            cum_in = cum_sum;
            if (reached || idx_ff == LAST_BIN) begin
               rsp_in.level = 8'(idx_ff);
               strobe_in    = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               idx_in   = idx_ff + bin_idx_type'(1);
               state_in = ST_QRY_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         total_ff  <= '0;
         peak_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         total_ff  <= total_in;
         peak_ff   <= peak_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cum_ff <= cum_in;
      rhs_ff <= rhs_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

`default_nettype wire

@@ design/lhp_bin_store.sv @@
`default_nettype none

module lhp_bin_store (
   input  wire                 clock,
   input  wire                 reset,
   input  lhp_pkg::bin_wr_type wr,
   input  lhp_pkg::bin_idx_type rd_addr,
   output lhp_pkg::count_type  rd_data
);
   import lhp_pkg::*;

   count_type           mem_ff [BINS];
   logic [BINS-1:0]     vld_ff;
   count_type           rd_raw_ff;
   logic                rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_raw_ff <= mem_ff[rd_addr];
   end

   // per-entry valid bits: a bin never written since reset reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_raw_ff : '0;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lhp_pkg::*;

   // Run limit in clocks. The slowest clean run is roughly 425 words, each a full
   // 256-bin query walk plus the longest sender gap.
   localparam int          CYCLE_LIMIT = 1_000_000;
   localparam int          SETTLE_CLKS = 16;
   localparam int          RANDOM_CMDS = 400;
   localparam logic [16:0] FULL_RATIO  = 17'd65536;

   // One queued word for the driver. With hold_for_drain set, the driver holds
   // start low until every result already owed has come back.
   typedef struct packed {
      logic    hold_for_drain;
      req_type word;
   } queued_cmd_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_strobe;
   rsp_type rsp_word;

   luma_histogram_percentile dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // ---------------------------------------------------------------------------
   // Histogram predictor: own copy of the bin counts, pixel total and peak.
   // ---------------------------------------------------------------------------
   count_type luma_hist [BINS];
   count_type pixel_count  = '0;
   count_type tallest_bin  = '0;

   queued_cmd_type cmd_backlog [$];  // words not yet taken by the block
   rsp_type        due_stats   [$];  // predicted results, oldest first

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   bit  word_taken     = 1'b0;       // a word was accepted at the last rising edge
   int  burst_left     = 1;
   int  gap_left       = 0;

   initial begin
      for (int i = 0; i < BINS; i++)
         luma_hist[i] = '0;
   end

   function automatic count_type bump(input count_type v);
      return (v == '1) ? v : v + count_type'(1);
   endfunction

   // (77R + 151G + 28B) >> 8; the weights add to 256 so the result fits a byte
   function automatic logic [7:0] pixel_luma(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
      logic [17:0] weighted;
      weighted = 18'(r) * 18'(LUMA_R) + 18'(g) * 18'(LUMA_G) + 18'(b) * 18'(LUMA_B);
      return 8'(weighted >> LUMA_SHIFT);
   endfunction

   // Smallest bin whose running count times 2^16 reaches ratio times total.
   // Exact: 80-bit products, running sum clamps at 2^64-1.
   function automatic bin_idx_type percentile_bin(input logic [RATIO_BITS-1:0] ratio);
      logic [63:0] running;
      logic [79:0] need;
      logic [79:0] have;
      bin_idx_type found;
      bit          hit;
      if (ratio == '0)
         return '0;
      if (ratio >= FULL_RATIO || pixel_count == '0)
         return LAST_BIN;
      running = '0;
      found   = LAST_BIN;
      hit     = 1'b0;
      need    = 80'(ratio) * 80'(pixel_count);
      for (int i = 0; i < BINS; i++) begin
         if (!hit) begin
            if (running > ~64'd0 - 64'(luma_hist[i]))
               running = ~64'd0;
            else
               running = running + 64'(luma_hist[i]);
            have = {running, 16'h0000};
            if (have >= need) begin
               found = bin_idx_type'(i);
               hit   = 1'b1;
            end
         end
      end
      return found;
   endfunction

   // Apply one accepted word to the predicted state, return the result it owes.
   function automatic rsp_type histogram_step(input req_type w);
      rsp_type     r;
      bin_idx_type bin;
      if (w.command == CMD_ADD) begin
         bin            = pixel_luma(w.red, w.green, w.blue);
         luma_hist[bin] = bump(luma_hist[bin]);
         pixel_count    = bump(pixel_count);
         if (luma_hist[bin] > tallest_bin)
            tallest_bin = luma_hist[bin];
         r.level = bin;
      end else begin
         // a query leaves the histogram alone
         r.level = percentile_bin(w.ratio);
      end
      r.peak_count  = OUT_BITS'(tallest_bin);
      r.pixel_total = OUT_BITS'(pixel_count);
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------------
   // Word builders. Fields a command ignores still get random values.
   // ---------------------------------------------------------------------------
   function automatic queued_cmd_type pixel_cmd(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
      queued_cmd_type c;
      c.hold_for_drain = 1'b0;
      c.word.command   = CMD_ADD;
      c.word.red       = r;
      c.word.green     = g;
      c.word.blue      = b;
      c.word.ratio     = RATIO_BITS'($urandom_range(0, 65536));
      return c;
   endfunction

   function automatic queued_cmd_type query_cmd(input logic [16:0] ratio);
      queued_cmd_type c;
      c.hold_for_drain = 1'b0;
      c.word.command   = CMD_QUERY;
      c.word.red       = 8'($urandom);
      c.word.green     = 8'($urandom);
      c.word.blue      = 8'($urandom);
      c.word.ratio     = ratio;
      return c;
   endfunction

   // Mostly pixels, about one query in six. Pixel mix: full-range RGB, pure grays
   // (luma equals the gray value), tight clusters that stack bins, black and white.
   function automatic queued_cmd_type random_cmd();
      int          pick;
      logic [7:0]  base;
      logic [16:0] ratio;
      pick = $urandom_range(0, 99);
      if (pick < 16) begin
         case ($urandom_range(0, 9))
            0:       ratio = 17'd0;
            1:       ratio = FULL_RATIO;
            2:       ratio = 17'($urandom_range(1, 16));
            3:       ratio = 17'($urandom_range(65520, 65535));
            default: ratio = 17'($urandom_range(1, 65535));
         endcase
         return query_cmd(ratio);
      end
      base = 8'($urandom);
      if (pick < 60)
         return pixel_cmd(8'($urandom), 8'($urandom), 8'($urandom));
      if (pick < 78)
         return pixel_cmd(base, base, base);
      if (pick < 96)
         return pixel_cmd(base ^ 8'($urandom_range(0, 3)), base ^ 8'($urandom_range(0, 3)),
                          base ^ 8'($urandom_range(0, 3)));
      return ($urandom_range(0, 1) == 0) ? pixel_cmd(8'h00, 8'h00, 8'h00)
                                         : pixel_cmd(8'hff, 8'hff, 8'hff);
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: changes inputs on the falling edge. Works in bursts; start stays
   // high across a burst, so back-to-back words see busy gaps of every length.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin : driver
      if (!reset) begin
         if (word_taken) begin
            void'(cmd_backlog.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               // one burst in four is long, to get stretches with no idling
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 10);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
         if (start && !word_taken) begin
            // word still on offer, hold it
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (cmd_backlog.size() != 0 &&
                      (!cmd_backlog[0].hold_for_drain || due_stats.size() == 0)) begin
            start    <= 1'b1;
            req_word <= cmd_backlog[0].word;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: samples on the rising edge. Each strobe is checked against the
   // oldest prediction; each accepted word adds a new prediction.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (due_stats.size() == 0) begin
               report_mismatch("result word with no prediction pending");
            end else begin
               want = due_stats.pop_front();
               if (rsp_word.level !== want.level)
                  report_mismatch($sformatf("level got %0d want %0d",
                                            rsp_word.level, want.level));
               if (rsp_word.peak_count !== want.peak_count)
                  report_mismatch($sformatf("peak_count got %0d want %0d",
                                            rsp_word.peak_count, want.peak_count));
               if (rsp_word.pixel_total !== want.pixel_total)
                  report_mismatch($sformatf("pixel_total got %0d want %0d",
                                            rsp_word.pixel_total, want.pixel_total));
            end
         end
         if (start && !busy) begin
            due_stats.push_back(histogram_step(req_word));
            word_taken <= 1'b1;
         end else begin
            word_taken <= 1'b0;
         end
      end else begin
         word_taken <= 1'b0;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus and end of run.
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      queued_cmd_type c;

      // empty histogram: any nonzero ratio lands in the last bin, zero in bin 0
      cmd_backlog.push_back(query_cmd(17'd32768));
      cmd_backlog.push_back(query_cmd(17'd0));
      cmd_backlog.push_back(query_cmd(FULL_RATIO));
      // luma extremes, the three primaries, two grays and a repeated black
      cmd_backlog.push_back(pixel_cmd(8'h00, 8'h00, 8'h00));
      cmd_backlog.push_back(pixel_cmd(8'hff, 8'hff, 8'hff));
      cmd_backlog.push_back(pixel_cmd(8'hff, 8'h00, 8'h00));
      cmd_backlog.push_back(pixel_cmd(8'h00, 8'hff, 8'h00));
      cmd_backlog.push_back(pixel_cmd(8'h00, 8'h00, 8'hff));
      cmd_backlog.push_back(pixel_cmd(8'h80, 8'h80, 8'h80));
      cmd_backlog.push_back(pixel_cmd(8'h01, 8'h01, 8'h01));
      cmd_backlog.push_back(pixel_cmd(8'h00, 8'h00, 8'h00));  // peak goes to 2
      // queries over a small populated histogram, including exact-boundary ratios
      cmd_backlog.push_back(query_cmd(17'd0));
      cmd_backlog.push_back(query_cmd(17'd1));
      cmd_backlog.push_back(query_cmd(17'd16384));
      cmd_backlog.push_back(query_cmd(17'd32768));
      cmd_backlog.push_back(query_cmd(17'd49152));
      cmd_backlog.push_back(query_cmd(17'd65535));
      cmd_backlog.push_back(query_cmd(FULL_RATIO));
      // ignored fields driven to their extremes
      c = query_cmd(17'd8192);
      c.word.red   = 8'hff;
      c.word.green = 8'hff;
      c.word.blue  = 8'hff;
      cmd_backlog.push_back(c);
      c = pixel_cmd(8'h40, 8'hc0, 8'h20);
      c.word.ratio = FULL_RATIO;
      cmd_backlog.push_back(c);
      cmd_backlog.push_back(query_cmd(17'd32768));

      for (int i = 0; i < RANDOM_CMDS; i++) begin
         c = random_cmd();
         // sender drains the block at the start of the random part and midway
         if (i == 0 || i == RANDOM_CMDS / 2)
            c.hold_for_drain = 1'b1;
         cmd_backlog.push_back(c);
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (cmd_backlog.size() != 0 || due_stats.size() != 0)
         @(posedge clock);
      // results are registered; the settle wait catches any stray strobe
      repeat (SETTLE_CLKS) @(posedge clock);

      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
